FILE: rtl/weigh_module_frame_parser_top_macros.svh
// ----------------------------------------------------------------------------
// Weigh module frame parser assertion macros
// Concurrent assertion shorthands on the local clk and rst.
// ----------------------------------------------------------------------------
`ifndef WEIGH_MODULE_FRAME_PARSER_TOP_MACROS_SVH
`define WEIGH_MODULE_FRAME_PARSER_TOP_MACROS_SVH

// Same-cycle implication, quiet during reset.
`define WMFP_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, quiet during reset.
`define WMFP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wmfp_pkg.sv
// ----------------------------------------------------------------------------
// Weigh module frame parser package
// Shared constants, types and decode functions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wmfp_pkg;

  localparam int DIGIT_COUNT = 7;
  localparam int END_POS     = DIGIT_COUNT + 6;
  localparam int POS_W       = $clog2(END_POS + 1);

  localparam logic [7:0] START_BYTE = 8'h01;
  localparam logic [7:0] END_BYTE   = 8'h04;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_PLUS  = 8'h2b;
  localparam logic [31:0] ASCII_ZERO = 32'd48;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;
  localparam logic REG_GRAM_IDX = 1'b0;

  localparam logic [3:0] MODE_NONE   = 4'd0;
  localparam logic [3:0] MODE_KG     = 4'd1;
  localparam logic [3:0] MODE_RAW1   = 4'd2;
  localparam logic [3:0] MODE_RAW2   = 4'd3;
  localparam logic [3:0] MODE_RAW3   = 4'd4;
  localparam logic [3:0] MODE_RAW4   = 4'd5;
  localparam logic [3:0] MODE_RAW5   = 4'd6;
  localparam logic [3:0] MODE_LB     = 4'd7;
  localparam logic [3:0] MODE_ERR    = 4'd8;
  localparam logic [3:0] MODE_INIT   = 4'd9;
  localparam logic [3:0] MODE_EEPROM = 4'd10;
  localparam logic [3:0] MODE_OK     = 4'd11;

  localparam logic [3:0] NIB_KG = 4'h0;
  localparam logic [3:0] NIB_LB = 4'h7;

  localparam logic [1:0] UNIT_KG = 2'd0;
  localparam logic [1:0] UNIT_G  = 2'd1;
  localparam logic [1:0] UNIT_LB = 2'd2;

  typedef enum logic [2:0] {
    K_HI_NIB,
    K_STATUS,
    K_COMMAND,
    K_SIGN,
    K_DIGIT,
    K_END
  } wmfp_kind_t;

  typedef struct packed {
    wmfp_kind_t  kind;
    logic [3:0]  nib;
    logic [7:0]  data;
  } wmfp_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } wmfp_q_stat_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) v = c[3:0];
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) v = c[3:0] + 4'd9;
    return v;
  endfunction

  function automatic logic [3:0] mode_of(input logic [3:0] hi);
    logic [3:0] m;
    case (hi)
      4'h0: m = MODE_KG;
      4'h1: m = MODE_RAW1;
      4'h2: m = MODE_RAW2;
      4'h3: m = MODE_RAW3;
      4'h4: m = MODE_RAW4;
      4'h5: m = MODE_RAW5;
      4'h7: m = MODE_LB;
      4'h8: m = MODE_ERR;
      4'h9: m = MODE_INIT;
      4'hA: m = MODE_EEPROM;
      4'hF: m = MODE_OK;
      default: m = MODE_NONE;
    endcase
    return m;
  endfunction

endpackage

FILE: rtl/wmfp_if.sv
// ----------------------------------------------------------------------------
// Weigh module frame parser channels
// Valid/ready byte channel and result channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wmfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface wmfp_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] weight_value;
  logic [7:0]         command_code;
  logic [7:0]         status_byte;
  logic [3:0]         data_mode;
  logic [1:0]         weight_unit;
  logic               zero_mark;
  logic               overload_mark;
  logic               tare_mark;
  logic               stable_mark;
  logic               changed;

  modport source (output valid, output weight_value, output command_code,
                  output status_byte, output data_mode, output weight_unit,
                  output zero_mark, output overload_mark, output tare_mark,
                  output stable_mark, output changed, input ready);
  modport sink (input valid, input weight_value, input command_code,
                input status_byte, input data_mode, input weight_unit,
                input zero_mark, input overload_mark, input tare_mark,
                input stable_mark, input changed, output ready);
endinterface

FILE: rtl/weigh_module_frame_parser_top.sv
// ----------------------------------------------------------------------------
// Weigh module frame parser top level
// Serial frame parser for a weighing module link, with an APB register.
//
//   channel   dir   handshake      payload
//   rx        in    valid/ready    rx_byte[7:0]
//   res       out   valid/ready    value, command, status, mode, unit, flags
//   apb       in    psel/penable   gram_display at byte address 0
//
// One byte per cycle in steady state; the front end, the tag queue and the
// back end each handle one byte a cycle. A good frame end reaches res in the
// cycle after the back end pops it.
// Synchronous reset rst clears positions, queue, history and result valid.
// A stall on res holds frame ends in the queue; the front end then stops
// only once the four-entry queue fills. Bytes outside a frame are dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "weigh_module_frame_parser_top_macros.svh"

module weigh_module_frame_parser_top (
  input  logic                          clk,
  input  logic                          rst,
  wmfp_byte_if.sink                     rx,
  wmfp_result_if.source                 res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wmfp_pkg::PADDR_W-1:0]  paddr,
  input  logic [wmfp_pkg::PDATA_W-1:0]  pwdata,
  output logic [wmfp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);
  import wmfp_pkg::*;

  logic          gram_display;
  logic          cfg_write;
  logic          q_push;
  logic          q_pop;
  wmfp_entry_t   q_wr_entry;
  wmfp_entry_t   q_rd_entry;
  wmfp_q_stat_t  q_stat;

  // Register file: a single control bit, written in the access phase.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      gram_display <= 1'b0;
    end else if (cfg_write && paddr[2] == REG_GRAM_IDX) begin
      gram_display <= pwdata[0];
    end
  end

  // Read back the register; holes read as zero.
  assign prdata = (paddr[2] == REG_GRAM_IDX) ? {{(PDATA_W-1){1'b0}}, gram_display} : '0;

  // Front end: hunt for start, tag frame bytes by position.
  wmfp_front u_front (
    .clk    (clk),
    .rst    (rst),
    .rx     (rx),
    .q_stat (q_stat),
    .push   (q_push),
    .entry  (q_wr_entry)
  );

  // Tag queue decouples the byte stream from result back-pressure.
  wmfp_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wr_entry (q_wr_entry),
    .pop      (q_pop),
    .rd_entry (q_rd_entry),
    .q_stat   (q_stat)
  );

  // Back end: accumulate fields, check the end byte, emit the result.
  wmfp_back u_back (
    .clk          (clk),
    .rst          (rst),
    .gram_display (gram_display),
    .rd_entry     (q_rd_entry),
    .q_stat       (q_stat),
    .pop          (q_pop),
    .res          (res)
  );

  `WMFP_ASSERT_IMPLIES(a_no_overflow, q_push, !q_stat.full, "queue push while full")
  `WMFP_ASSERT_IMPLIES(a_no_underflow, q_pop, !q_stat.empty, "queue pop while empty")
  `WMFP_ASSERT_IMPLIES(a_lb_unit, res.valid && res.data_mode == MODE_LB, res.weight_unit == UNIT_LB, "lb frame without lb unit")

endmodule

FILE: rtl/wmfp_front.sv
// ----------------------------------------------------------------------------
// Weigh module frame parser front end
// Tracks frame position, tags each byte and decodes hex characters.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmfp_front (
  input  logic                  clk,
  input  logic                  rst,
  wmfp_byte_if.sink             rx,
  input  wmfp_pkg::wmfp_q_stat_t q_stat,
  output logic                  push,
  output wmfp_pkg::wmfp_entry_t entry
);
  import wmfp_pkg::*;

  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] pos_next;
  logic             hunting;
  logic             take;

  assign hunting  = (pos == '0);
  // Hunting bytes are dropped, so they never wait on the queue.
  assign rx.ready = hunting || !q_stat.full;
  assign take     = rx.valid && rx.ready;
  assign push     = take && !hunting;

  always_comb begin
    entry.data = rx.rx_byte;
    entry.nib  = hex_value(rx.rx_byte);
    if (pos == POS_W'(1) || pos == POS_W'(3)) begin
      entry.kind = K_HI_NIB;
    end else if (pos == POS_W'(2)) begin
      entry.kind = K_STATUS;
    end else if (pos == POS_W'(4)) begin
      entry.kind = K_COMMAND;
    end else if (pos == POS_W'(5)) begin
      entry.kind = K_SIGN;
    end else if (pos < POS_W'(END_POS)) begin
      entry.kind = K_DIGIT;
    end else begin
      entry.kind = K_END;
    end
  end

  always_comb begin
    pos_next = pos;
    if (take) begin
      if (hunting) begin
        if (rx.rx_byte == START_BYTE) pos_next = POS_W'(1);
      end else if (pos == POS_W'(END_POS)) begin
        pos_next = '0;
      end else begin
        pos_next = pos + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

FILE: rtl/wmfp_queue.sv
// ----------------------------------------------------------------------------
// Weigh module frame parser queue
// Short FIFO of tagged bytes between front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmfp_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  wmfp_pkg::wmfp_entry_t  wr_entry,
  input  logic                   pop,
  output wmfp_pkg::wmfp_entry_t  rd_entry,
  output wmfp_pkg::wmfp_q_stat_t q_stat
);
  import wmfp_pkg::*;

  wmfp_entry_t     slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign q_stat.full  = (count == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (count == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign rd_entry     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= wr_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + Q_AW'(1);
      if (do_pop) rd_ptr <= rd_ptr + Q_AW'(1);
      if (do_push && !do_pop) count <= count + Q_CW'(1);
      else if (do_pop && !do_push) count <= count - Q_CW'(1);
    end
  end

endmodule

FILE: rtl/wmfp_back.sv
// ----------------------------------------------------------------------------
// Weigh module frame parser back end
// Assembles status, command and value, and registers the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wmfp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   gram_display,
  input  wmfp_pkg::wmfp_entry_t  rd_entry,
  input  wmfp_pkg::wmfp_q_stat_t q_stat,
  output logic                   pop,
  wmfp_result_if.source          res
);
  import wmfp_pkg::*;

  logic [3:0]  high_nibble;
  logic [7:0]  status_held;
  logic [7:0]  command_held;
  logic        negative_flag;
  logic [31:0] accumulator;
  logic [7:0]  previous_status;
  logic [31:0] previous_value;
  logic [1:0]  current_unit;

  logic        out_valid;
  logic [31:0] out_value;
  logic [7:0]  out_command;
  logic [7:0]  out_status;
  logic [3:0]  out_mode;
  logic [1:0]  out_unit;
  logic        out_changed;

  logic        slot_free;
  logic        good_end;
  logic [31:0] digit_term;
  logic [31:0] value;
  logic [1:0]  unit_next;
  logic        changed_next;

  assign slot_free  = !out_valid || res.ready;
  // Stall only a frame end, and only while the result register is full.
  assign pop        = !q_stat.empty && (rd_entry.kind != K_END || slot_free);
  assign good_end   = pop && rd_entry.kind == K_END && rd_entry.data == END_BYTE;
  assign digit_term = {24'd0, rd_entry.data} - ASCII_ZERO;
  assign value      = negative_flag ? (32'd0 - accumulator) : accumulator;

  always_comb begin
    unit_next = current_unit;
    if (status_held[7:4] == NIB_KG) unit_next = gram_display ? UNIT_G : UNIT_KG;
    else if (status_held[7:4] == NIB_LB) unit_next = UNIT_LB;
  end

  assign changed_next = (status_held != previous_status) || (value != previous_value);

  always_ff @(posedge clk) begin
    if (rst) begin
      high_nibble     <= '0;
      status_held     <= '0;
      command_held    <= '0;
      negative_flag   <= 1'b0;
      accumulator     <= '0;
      previous_status <= '0;
      previous_value  <= '0;
      current_unit    <= UNIT_KG;
    end else if (pop) begin
      case (rd_entry.kind)
        K_HI_NIB:  high_nibble  <= rd_entry.nib;
        K_STATUS:  status_held  <= {high_nibble, rd_entry.nib};
        K_COMMAND: command_held <= {high_nibble, rd_entry.nib};
        K_SIGN: begin
          negative_flag <= (rd_entry.data == CHAR_MINUS);
          if (rd_entry.data == CHAR_MINUS || rd_entry.data == CHAR_PLUS) accumulator <= '0;
          else accumulator <= digit_term;
        end
        K_DIGIT: accumulator <= (accumulator << 3) + (accumulator << 1) + digit_term;
        K_END: begin
          if (good_end) begin
            previous_status <= status_held;
            previous_value  <= value;
            current_unit    <= unit_next;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (good_end) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (good_end) begin
      out_value   <= value;
      out_command <= command_held;
      out_status  <= status_held;
      out_mode    <= mode_of(status_held[7:4]);
      out_unit    <= unit_next;
      out_changed <= changed_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.weight_value  = out_value;
  assign res.command_code  = out_command;
  assign res.status_byte   = out_status;
  assign res.data_mode     = out_mode;
  assign res.weight_unit   = out_unit;
  assign res.zero_mark     = out_status[3];
  assign res.overload_mark = out_status[2];
  assign res.tare_mark     = out_status[1];
  assign res.stable_mark   = out_status[0];
  assign res.changed       = out_changed;

endmodule
